// File: design/bcpt_pkg.sv
// ----------------------------------------------------------------------------
// bcpt_pkg
// Shared types, constants and the busy test for the busy-client priority table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcpt_pkg;

  // Default table geometry.
  localparam int FD_COUNT_DEF = 1024;
  localparam int BUSY_BIT_DEF = 0;

  // Field widths fixed by the interface.
  localparam int IDX_W   = 10;
  localparam int FLAG_W  = 8;
  localparam int PRIO_W  = 7;
  localparam int COUNT_W = 32;

  // Operation codes.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_DEL   = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OVERLOAD = 2'd0;
  localparam logic [1:0] CFG_STRICT   = 2'd1;
  localparam logic [1:0] CFG_RELAXED  = 2'd2;

  // Priority aging constants.
  localparam logic [PRIO_W-1:0] PRIO_CAP  = 7'd90;
  localparam logic [PRIO_W-1:0] PRIO_RISE = 7'd2;
  localparam logic [PRIO_W-1:0] PRIO_DROP = 7'd30;

  // Threshold values after reset.
  localparam logic [PRIO_W-1:0] STRICT_RESET  = 7'd40;
  localparam logic [PRIO_W-1:0] RELAXED_RESET = 7'd60;

  typedef struct packed {
    logic [COUNT_W-1:0] last_count;
    logic [PRIO_W-1:0]  prio;
    logic [FLAG_W-1:0]  flags;
  } entry_t;

  typedef struct packed {
    logic              overload;
    logic [PRIO_W-1:0] strict_thr;
    logic [PRIO_W-1:0] relaxed_thr;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic               in_range;
    logic [IDX_W-1:0]   fd_index;
    logic [FLAG_W-1:0]  mask;
    logic               client_present;
    logic               privileged;
    logic [COUNT_W-1:0] recv_count;
  } item_t;

  // A priority below the strict threshold is always busy; below the relaxed
  // threshold it is busy only while overload mode is off.
  function automatic logic is_busy(input logic [PRIO_W-1:0] prio, input cfg_t cfg);
    is_busy = (prio < cfg.strict_thr) || (!cfg.overload && (prio < cfg.relaxed_thr));
  endfunction

endpackage

// File: design/bcpt_table.sv
// ----------------------------------------------------------------------------
// bcpt_table
// Entry memory with one write port, one registered read port and a clearing
// sweep that zeroes every entry after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcpt_table #(
  parameter int FD_COUNT = 1024,
  parameter int AW       = $clog2(FD_COUNT)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output bcpt_pkg::entry_t rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  bcpt_pkg::entry_t wr_data,
  output logic             clear_done
);
  import bcpt_pkg::*;

  localparam logic [AW-1:0] LAST_ADDR = AW'(FD_COUNT - 1);

  entry_t        mem [FD_COUNT];
  logic          clearing;
  logic [AW-1:0] clear_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;

  assign clear_done = !clearing;

  // The sweep owns the write port while it runs; no items arrive then.
  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_en;
      mem_waddr = wr_addr;
      mem_wdata = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + AW'(1);
      if (clear_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/bcpt_update.sv
// ----------------------------------------------------------------------------
// bcpt_update
// Computes the new contents of one entry for add, delete and check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcpt_update #(
  parameter int BUSY_BIT = 0
) (
  input  bcpt_pkg::item_t  item,
  input  bcpt_pkg::cfg_t   cfg,
  input  bcpt_pkg::entry_t old_entry,
  output bcpt_pkg::entry_t new_entry,
  output logic             aged
);
  import bcpt_pkg::*;

  localparam logic [FLAG_W-1:0] BUSY_MASK = FLAG_W'(1) << BUSY_BIT;

  always_comb begin
    logic [PRIO_W:0]   prio_rise;
    logic [PRIO_W-1:0] prio;
    logic              busy;

    new_entry = old_entry;
    aged      = 1'b0;
    prio_rise = {1'b0, old_entry.prio} + {1'b0, PRIO_RISE};
    prio      = old_entry.prio;
    busy      = 1'b0;

    case (item.opcode)
      OP_ADD: begin
        new_entry.flags = old_entry.flags | item.mask;
      end
      OP_DEL: begin
        new_entry.flags = old_entry.flags & ~item.mask;
      end
      OP_CHECK: begin
        if (item.client_present && !item.privileged) begin
          aged = 1'b1;
          if (item.recv_count == old_entry.last_count) begin
            // Quiet client: priority climbs toward the cap.
            if (prio_rise > {1'b0, PRIO_CAP}) begin
              prio = PRIO_CAP;
              busy = 1'b0;
            end else begin
              prio = prio_rise[PRIO_W-1:0];
              busy = is_busy(prio, cfg);
            end
          end else begin
            // Active client: record the count and drop the priority.
            new_entry.last_count = item.recv_count;
            if (old_entry.prio < PRIO_DROP) begin
              prio = '0;
              busy = 1'b1;
            end else begin
              prio = old_entry.prio - PRIO_DROP;
              busy = is_busy(prio, cfg);
            end
          end
          new_entry.prio  = prio;
          new_entry.flags = (old_entry.flags & ~BUSY_MASK) | (busy ? BUSY_MASK : '0);
        end
      end
      default: begin
        new_entry = old_entry;
      end
    endcase
  end

endmodule

// File: design/busy_client_priority_table_core.sv
// Result path: an accepted input beat is held in stage 1 during its entry read,
// then loaded into the output register. Throughput: one beat per cycle while the
// result stream does not stall; a read-modify-write on the entry memory, with the
// last written entry forwarded so back-to-back beats to one index are exact.
// Reset: synchronous, active high; a sweep then clears all entries with s_tready
// low, configuration still accepted; thresholds reset to 40 and 60, overload off.
// ----------------------------------------------------------------------------
// busy_client_priority_table_core
// Per-connection flag, priority and message count table with mask add/delete
// and priority aging that maintains a busy flag bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module busy_client_priority_table_core #(
  parameter int FD_COUNT = bcpt_pkg::FD_COUNT_DEF,
  parameter int BUSY_BIT = bcpt_pkg::BUSY_BIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // [9:0] fd_index, [17:10] mask, [18] client_present, [19] privileged,
  // [51:20] recv_count, [55:52] zero
  input  logic [55:0] s_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_tuser,
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] flags, [14:8] priority_res, [15] busy_res, [16] aged, [23:17] zero
  output logic [23:0] m_tdata,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import bcpt_pkg::*;

  localparam int              AW       = $clog2(FD_COUNT);
  localparam logic [16:0]     FD_LIMIT = 17'(FD_COUNT);

  // Configuration registers.
  cfg_t cfg;

  // Stage 1 holds the accepted item while the memory read returns.
  logic   s1_valid;
  item_t  s1_item;
  logic   s1_go;
  logic   accept;
  item_t  in_item;

  // Forwarding of the most recent write.
  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  entry_t        fwd_entry;

  entry_t        rd_entry;
  entry_t        old_entry;
  entry_t        new_entry;
  logic          new_aged;
  logic [AW-1:0] s1_addr;
  logic          tbl_ready;
  logic          wr_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.overload    <= 1'b0;
      cfg.strict_thr  <= STRICT_RESET;
      cfg.relaxed_thr <= RELAXED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OVERLOAD: cfg.overload    <= cfg_data[0];
        CFG_STRICT:   cfg.strict_thr  <= cfg_data;
        CFG_RELAXED:  cfg.relaxed_thr <= cfg_data;
        default:      cfg             <= cfg;
      endcase
    end
  end

  // Unpack the input beat.
  always_comb begin
    in_item.opcode         = s_tuser;
    in_item.fd_index       = s_tdata[9:0];
    in_item.mask           = s_tdata[17:10];
    in_item.client_present = s_tdata[18];
    in_item.privileged     = s_tdata[19];
    in_item.recv_count     = s_tdata[51:20];
    in_item.in_range       = {7'd0, s_tdata[9:0]} < FD_LIMIT;
  end

  // Stage 1 moves on when the output register is free or is being drained.
  assign s1_go    = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = tbl_ready && (!s1_valid || s1_go);
  assign accept   = s_tvalid && s_tready;
  assign s1_addr  = AW'(s1_item.fd_index);
  assign wr_en    = s1_go && s1_item.in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
    end
  end

  bcpt_table #(
    .FD_COUNT (FD_COUNT),
    .AW       (AW)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (accept),
    .rd_addr    (AW'(in_item.fd_index)),
    .rd_data    (rd_entry),
    .wr_en      (wr_en),
    .wr_addr    (s1_addr),
    .wr_data    (new_entry),
    .clear_done (tbl_ready)
  );

  // The read issued on the same edge as the previous write misses that write,
  // so the entry written last is taken from the forwarding register instead.
  assign old_entry = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_entry : rd_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr  <= s1_addr;
      fwd_entry <= new_entry;
    end
  end

  bcpt_update #(
    .BUSY_BIT (BUSY_BIT)
  ) u_update (
    .item      (s1_item),
    .cfg       (cfg),
    .old_entry (old_entry),
    .new_entry (new_entry),
    .aged      (new_aged)
  );

  // Output register; an index beyond the table gives an all-zero result.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      if (s1_item.in_range) begin
        m_tdata <= {7'd0, new_aged, new_entry.flags[BUSY_BIT], new_entry.prio,
                    new_entry.flags};
      end else begin
        m_tdata <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // No beat is taken while the clearing sweep still owns the memory.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    !tbl_ready |-> !s_tready)
    else $error("input beat accepted during table clear");

  // A stalled stage 1 keeps its item until the output register frees up.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_item)))
    else $error("stage 1 item lost while stalled");

  // Only an in-range check of a present, unprivileged client ages an entry.
  a_aged_only_check: assert property (@(posedge clk) disable iff (rst)
    (s1_go && new_aged) |->
      (s1_item.opcode == OP_CHECK && s1_item.client_present && !s1_item.privileged))
    else $error("entry aged by an operation other than check");

  // Aged priority never exceeds the cap.
  a_prio_cap: assert property (@(posedge clk) disable iff (rst)
    (s1_go && new_aged) |-> (new_entry.prio <= PRIO_CAP))
    else $error("aged priority above cap");

  // A result register load always follows a valid stage 1 item.
  a_out_after_s1: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid)) |-> $past(s1_valid))
    else $error("result beat without a source item");
`endif

endmodule
